### src/lba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_pkg
// Shared types and field widths for the linked block allocator.
// ----------------------------------------------------------------------------
package lba_pkg;

  localparam int REQ_LEN_W   = 7;
  localparam int STATUS_W    = 2;
  localparam int FILE_SLOT_W = 4;
  localparam int BLK_IDX_W   = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

endpackage

### src/linked_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_block_allocator
// Allocates the lowest free disk blocks to a new file, chains them through a
// next-link table and reports each block in ascending order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  request   in         start_i, busy_o        request_length_i
//  result    out        valid_o (one cycle)    status_o, file_slot_o,
//                                              block_index_o, block_valid_o,
//                                              last_o
//
//  A failed or zero-length request answers in the cycle after it is taken,
//  without raising busy_o. Otherwise busy_o stays high through a read-latency
//  step, a scan of the blocks from block 0 (a result for each block taken)
//  and a commit step; the next request is taken only once busy_o is low.
//  Reset leaves every block free and the file table empty; no clearing pass.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
module linked_block_allocator
  import lba_pkg::*;
#(
  parameter int DISK_BLOCKS = 64,
  parameter int FILE_SLOTS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [REQ_LEN_W-1:0]   request_length_i,
  output logic                   valid_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [FILE_SLOT_W-1:0] file_slot_o,
  output logic [BLK_IDX_W-1:0]   block_index_o,
  output logic                   block_valid_o,
  output logic                   last_o
);

  localparam int BW  = $clog2(DISK_BLOCKS);
  localparam int CW  = $clog2(DISK_BLOCKS + 1);
  localparam int LW  = CW;
  localparam int KW  = (CW > REQ_LEN_W) ? CW : REQ_LEN_W;
  localparam int FCW = $clog2(FILE_SLOTS + 1);
  localparam int SW  = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam logic [LW-1:0] EndOfChain = LW'(DISK_BLOCKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        used_cnt_q;  // blocks in use; always a prefix of the disk
  logic [FCW-1:0]       file_cnt_q;
  logic [SW-1:0]        slot_q;
  logic [REQ_LEN_W-1:0] want_q;
  logic [REQ_LEN_W-1:0] got_q;
  logic [BW-1:0]        scan_q;
  logic [BW-1:0]        pend_q;
  logic                 pend_vld_q;
  logic                 below_q;
  logic [BW-1:0]        prev_q;
  logic                 has_prev_q;

  // memories
  logic                 used_mem  [DISK_BLOCKS];
  logic [LW-1:0]        link_mem  [DISK_BLOCKS];
  logic [LW-1:0]        start_mem [FILE_SLOTS];
  logic                 used_rd_q;

  logic                 accept;
  logic [KW-1:0]        free_ext;
  logic                 nospace;
  logic                 full;
  logic                 zero_len;
  logic                 found;
  logic                 fin;
  logic                 link_we;
  logic [LW-1:0]        link_wd;
  logic                 start_we;
  logic [SW-1:0]        start_wa;
  logic [LW-1:0]        start_wd;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign free_ext = KW'(DISK_BLOCKS) - KW'(used_cnt_q);
  assign nospace  = KW'(request_length_i) > free_ext;
  assign full     = file_cnt_q >= FCW'(FILE_SLOTS);
  assign zero_len = (request_length_i == '0);

  // entries beyond the fill count read as free whatever the memory holds
  assign found = (state_q == S_SCAN) && pend_vld_q && !(used_rd_q && below_q);
  assign fin   = found && ((got_q + 1'b1) == want_q);

  assign link_we  = (found && has_prev_q) || (state_q == S_COMMIT);
  assign link_wd  = (state_q == S_COMMIT) ? EndOfChain : LW'(pend_q);
  assign start_we = (accept && !nospace && !full) || (found && !has_prev_q);
  assign start_wa = (state_q == S_IDLE) ? file_cnt_q[SW-1:0] : slot_q;
  assign start_wd = (state_q == S_IDLE) ? EndOfChain : LW'(pend_q);

  always_ff @(posedge clk_i) begin
    if (found) used_mem[pend_q] <= 1'b1;
    used_rd_q <= used_mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[prev_q] <= link_wd;
  end

  always_ff @(posedge clk_i) begin
    if (start_we) start_mem[start_wa] <= start_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      used_cnt_q    <= '0;
      file_cnt_q    <= '0;
      slot_q        <= '0;
      want_q        <= '0;
      got_q         <= '0;
      scan_q        <= '0;
      pend_q        <= '0;
      pend_vld_q    <= 1'b0;
      below_q       <= 1'b0;
      prev_q        <= '0;
      has_prev_q    <= 1'b0;
      valid_o       <= 1'b0;
      status_o      <= ST_OK;
      file_slot_o   <= '0;
      block_index_o <= '0;
      block_valid_o <= 1'b0;
      last_o        <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            valid_o       <= 1'b1;
            file_slot_o   <= '0;
            block_index_o <= '0;
            block_valid_o <= 1'b0;
            last_o        <= 1'b1;
            priority if (nospace) begin
              status_o <= ST_NOSPACE;
            end else if (full) begin
              status_o <= ST_FULL;
            end else begin
              file_cnt_q <= file_cnt_q + 1'b1;
              slot_q     <= file_cnt_q[SW-1:0];
              if (zero_len) begin
                status_o    <= ST_OK;
                file_slot_o <= FILE_SLOT_W'(file_cnt_q);
              end else begin
                valid_o    <= 1'b0;
                want_q     <= request_length_i;
                got_q      <= '0;
                scan_q     <= '0;
                pend_vld_q <= 1'b0;
                has_prev_q <= 1'b0;
                state_q    <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          scan_q     <= scan_q + 1'b1;
          pend_q     <= scan_q;
          pend_vld_q <= 1'b1;
          below_q    <= CW'(scan_q) < used_cnt_q;
          if (found) begin
            valid_o       <= 1'b1;
            status_o      <= ST_OK;
            file_slot_o   <= FILE_SLOT_W'(slot_q);
            block_index_o <= BLK_IDX_W'(pend_q);
            block_valid_o <= 1'b1;
            last_o        <= fin;
            got_q         <= got_q + 1'b1;
            prev_q        <= pend_q;
            has_prev_q    <= 1'b1;
          end
          if (fin) begin
            pend_vld_q <= 1'b0;
            state_q    <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          // terminate the chain at prev_q and retire the blocks
          used_cnt_q <= used_cnt_q + CW'(want_q);
          state_q    <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/lba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_checker
// Port-level checks on the result stream of the linked block allocator.
// ----------------------------------------------------------------------------
module lba_checker
  import lba_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   valid_o,
  input logic [STATUS_W-1:0]    status_o,
  input logic [FILE_SLOT_W-1:0] file_slot_o,
  input logic [BLK_IDX_W-1:0]   block_index_o,
  input logic                   block_valid_o,
  input logic                   last_o
);

  // a failure is a single result carrying no block
  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != ST_OK) |-> last_o && !block_valid_o && (file_slot_o == '0))
    else $error("failure result not a lone final result");

  // blocks of one request come back to back once the first free one is found
  a_stream_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o && block_valid_o)
    else $error("gap inside a block stream");

  // ascending, contiguous block indexes within a request
  a_blocks_ascend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && block_valid_o && !last_o |=>
      (block_index_o - $past(block_index_o)) == BLK_IDX_W'(1))
    else $error("block indexes not ascending");

  // a taken request either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> valid_o || busy_o)
    else $error("request dropped");

  // an unfinished stream never ends while idle
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !busy_o |-> last_o)
    else $error("stream cut short");

endmodule

bind linked_block_allocator lba_checker u_lba_checker (.*);

### sim/tb_linked_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_block_allocator
// Self-checking bench for the linked block allocator. A scoreboard keeps its
// own used-block map, file count and free count, predicts every result of
// each accepted request and compares it field by field with the DUT output.
// Directed requests fill all but one disk block and the file table. Random requests then
// run with and without sender idle gaps.
// ----------------------------------------------------------------------------
module tb_linked_block_allocator;
  import lba_pkg::*;

  localparam int DISK_BLOCKS  = 64;
  localparam int FILE_SLOTS   = 16;
  localparam int DRAIN_CYCLES = DISK_BLOCKS + 8;

  typedef struct {
    status_e                status;
    logic [FILE_SLOT_W-1:0] file_slot;
    logic [BLK_IDX_W-1:0]   block_index;
    logic                   block_valid;
    logic                   last;
  } grant_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [REQ_LEN_W-1:0]   request_length_i;
  logic                   valid_o;
  logic [STATUS_W-1:0]    status_o;
  logic [FILE_SLOT_W-1:0] file_slot_o;
  logic [BLK_IDX_W-1:0]   block_index_o;
  logic                   block_valid_o;
  logic                   last_o;

  // scoreboard copy of the allocator state
  logic [DISK_BLOCKS-1:0] model_used;
  int unsigned            model_files;
  int unsigned            model_free;
  grant_t                 expected_grants[$];
  int unsigned            error_count;
  int unsigned            idle_pct;

  linked_block_allocator #(
    .DISK_BLOCKS (DISK_BLOCKS),
    .FILE_SLOTS  (FILE_SLOTS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .request_length_i (request_length_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .file_slot_o      (file_slot_o),
    .block_index_o    (block_index_o),
    .block_valid_o    (block_valid_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic grant_t make_grant(input status_e st, input int unsigned slot,
                                        input int unsigned blk, input logic bv,
                                        input logic lst);
    grant_t g;
    g.status      = st;
    g.file_slot   = slot[FILE_SLOT_W-1:0];
    g.block_index = blk[BLK_IDX_W-1:0];
    g.block_valid = bv;
    g.last        = lst;
    return g;
  endfunction

  // Expected results of one request; updates the scoreboard state.
  function automatic void predict_allocation(input int unsigned want);
    int unsigned slot;
    int unsigned got;
    got = 0;
    // free-space check wins over the table-full check
    if (want > model_free) begin
      expected_grants.push_back(make_grant(ST_NOSPACE, 0, 0, 1'b0, 1'b1));
    end else if (model_files >= FILE_SLOTS) begin
      expected_grants.push_back(make_grant(ST_FULL, 0, 0, 1'b0, 1'b1));
    end else begin
      slot = model_files;
      model_files++;
      if (want == 0) begin
        expected_grants.push_back(make_grant(ST_OK, slot, 0, 1'b0, 1'b1));
      end else begin
        for (int i = 0; i < DISK_BLOCKS && got < want; i++) begin
          if (!model_used[i]) begin
            model_used[i] = 1'b1;
            got++;
            expected_grants.push_back(make_grant(ST_OK, slot, i, 1'b1, got == want));
          end
        end
        model_free -= got;
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    grant_t head;
    if (rst_ni && valid_o) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status=%0d slot=%0d blk=%0d",
                 $time, status_o, file_slot_o, block_index_o);
        error_count++;
      end else begin
        head = expected_grants.pop_front();
        check_field("status", 8'(head.status), 8'(status_o));
        check_field("file_slot", 8'(head.file_slot), 8'(file_slot_o));
        check_field("block_index", 8'(head.block_index), 8'(block_index_o));
        check_field("block_valid", 8'(head.block_valid), 8'(block_valid_o));
        check_field("last", 8'(head.last), 8'(last_o));
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with start_i still
  // high unless an idle gap was inserted.
  task automatic send_request(input int unsigned len);
    int unsigned gap;
    start_i          <= 1'b1;
    request_length_i <= len[REQ_LEN_W-1:0];
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_allocation(len);
    @(negedge clk_i);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      // mostly short gaps, some long enough to span a whole block scan
      gap = ($urandom_range(7) == 0) ? $urandom_range(DISK_BLOCKS + 4, 1)
                                     : $urandom_range(3, 1);
      start_i          <= 1'b0;
      request_length_i <= REQ_LEN_W'($urandom_range(127));
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_zero_and_oversize();
    send_request(127);
    send_request(DISK_BLOCKS + 1);
    send_request(0);
  endtask

  task automatic test_allocate_lowest();
    send_request(1);
    send_request(DISK_BLOCKS);   // one block short now
    send_request(DISK_BLOCKS - 2);
    drain_results();
  endtask

  task automatic test_fill_table();
    while (model_files < FILE_SLOTS) send_request(0);
  endtask

  // one block is still free here
  task automatic test_full_table();
    send_request(1);
    send_request(0);
    send_request(2);
    send_request(127);
  endtask

  task automatic test_random(input int unsigned count, input int unsigned pct);
    idle_pct = pct;
    repeat (count) begin
      if ($urandom_range(7) == 0) send_request($urandom_range(2));
      else send_request($urandom_range(127));
    end
    drain_results();
  endtask

  initial begin
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    request_length_i = '0;
    model_used       = '0;
    model_files      = 0;
    model_free       = DISK_BLOCKS;
    error_count      = 0;
    idle_pct         = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_zero_and_oversize();
    test_allocate_lowest();
    test_fill_table();
    test_full_table();
    drain_results();

    test_random(134, 0);
    test_random(133, 45);
    test_random(133, 23);

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
src/lba_pkg.sv
src/linked_block_allocator.sv
src/lba_checker.sv
sim/tb_linked_block_allocator.sv
